// File: rtl/dlpp_pkg.sv
// Display list primitive parser: shared types, codes and helper functions.
// Used by the step logic, the top level and the testbench.
// No dependencies.
package dlpp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_INDEX  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // End reasons
  localparam logic [2:0] REASON_DATA_END   = 3'd0;
  localparam logic [2:0] REASON_ZERO_FLAGS = 3'd1;
  localparam logic [2:0] REASON_ZERO_COUNT = 3'd2;
  localparam logic [2:0] REASON_END_COUNT  = 3'd3;
  localparam logic [2:0] REASON_NO_MAIN    = 3'd4;
  localparam logic [2:0] REASON_TRUNCATED  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAIN_ATTR = 2'd0;
  localparam logic [1:0] CFG_SUB_ATTR  = 2'd1;

  localparam int unsigned NUM_SLOTS = 12;
  localparam logic [3:0]  LAST_SLOT_LIMIT = 4'(NUM_SLOTS);

  // Descriptor codes that read an index
  localparam logic [1:0] DESC_BYTE = 2'd2;
  localparam logic [1:0] DESC_WORD = 2'd3;

  typedef logic [NUM_SLOTS-1:0][1:0] desc_t;

  typedef enum logic [5:0] {
    PH_FLAGS  = 6'b000001,
    PH_CNT_HI = 6'b000010,
    PH_CNT_LO = 6'b000100,
    PH_SKIP   = 6'b001000,
    PH_IDX    = 6'b010000,
    PH_IDX2   = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  flags_held;
    logic [7:0]  count_high;
    logic [15:0] count_held;
    logic [15:0] vertex_counter;
    logic [3:0]  slot_counter;
    logic [2:0]  skip_bit;
    logic [7:0]  value_high;
    logic        stopped;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_FLAGS,
    flags_held:     8'd0,
    count_high:     8'd0,
    count_held:     16'd0,
    vertex_counter: 16'd0,
    slot_counter:   4'd0,
    skip_bit:       3'd0,
    value_high:     8'd0,
    stopped:        1'b0
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  primitive_type;
    logic [2:0]  format_index;
    logic [15:0] vertex_count;
    logic [15:0] vertex_number;
    logic [3:0]  attribute_slot;
    logic [15:0] attribute_value;
    logic        last_of_primitive;
    logic        stream_done;
    logic [2:0]  end_reason;
  } result_t;

  typedef struct packed {
    logic       found;
    logic [3:0] idx;
  } slot_pick_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } sub_pick_t;

  // Lowest slot at or above 'from' whose descriptor reads an index
  function automatic slot_pick_t first_slot(desc_t desc, logic [4:0] from);
    slot_pick_t pick;
    pick = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if ((5'(s) >= from) && (desc[s] >= DESC_BYTE)) begin
        pick.found = 1'b1;
        pick.idx   = 4'(s);
      end
    end
    return pick;
  endfunction

  // Lowest set sub mask bit at or above 'from'
  function automatic sub_pick_t first_sub(logic [7:0] mask, logic [3:0] from);
    sub_pick_t pick;
    pick = '0;
    for (int b = 7; b >= 0; b--) begin
      if ((4'(b) >= from) && mask[b]) begin
        pick.found = 1'b1;
        pick.idx   = 3'(b);
      end
    end
    return pick;
  endfunction

endpackage

// File: rtl/dlpp_if.sv
// Display list primitive parser: byte, result and configuration channels.
// Valid/ready handshakes; depends on nothing but plain widths.

interface dlpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       start_stream;

  modport source (output valid, data_byte, last_byte, start_stream, input ready);
  modport sink   (input valid, data_byte, last_byte, start_stream, output ready);
endinterface

interface dlpp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  primitive_type;
  logic [2:0]  format_index;
  logic [15:0] vertex_count;
  logic [15:0] vertex_number;
  logic [3:0]  attribute_slot;
  logic [15:0] attribute_value;
  logic        last_of_primitive;
  logic        stream_done;
  logic [2:0]  end_reason;

  modport source (output valid, kind, primitive_type, format_index, vertex_count,
                  vertex_number, attribute_slot, attribute_value, last_of_primitive,
                  stream_done, end_reason, input ready);
  modport sink   (input valid, kind, primitive_type, format_index, vertex_count,
                  vertex_number, attribute_slot, attribute_value, last_of_primitive,
                  stream_done, end_reason, output ready);
endinterface

interface dlpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dlpp_step.sv
// Display list primitive parser: next-state and result logic for one byte.
// Purely combinational; depends on dlpp_pkg.
module dlpp_step (
  input  dlpp_pkg::state_t  st,
  input  logic [23:0]       main_attributes,
  input  logic [7:0]        sub_attributes,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              start_stream,
  output dlpp_pkg::state_t  nxt,
  output logic              emit,
  output dlpp_pkg::result_t res
);
  import dlpp_pkg::*;

  desc_t       desc;
  sub_pick_t   sub_first;
  sub_pick_t   sub_after;
  slot_pick_t  slot_first;
  slot_pick_t  slot_after;
  logic [15:0] vc_inc;
  logic        fin_done;
  logic        cur_word;
  logic [15:0] count_word;

  logic        end_req;
  logic [2:0]  end_code;
  logic        hdr_req;
  logic        idx_req;
  logic        idx_done;
  logic [15:0] idx_value;

  // Moves to the next vertex, or closes the primitive
  function automatic state_t next_vertex(state_t s, logic [15:0] vc, logic done,
                                         sub_pick_t sp, slot_pick_t kp);
    state_t r;
    r = s;
    r.vertex_counter = vc;
    if (done) begin
      r.phase = PH_FLAGS;
    end else if (sp.found) begin
      r.phase    = PH_SKIP;
      r.skip_bit = sp.idx;
    end else begin
      r.phase        = PH_IDX;
      r.slot_counter = kp.idx;
    end
    return r;
  endfunction

  // Searches over the descriptor and sub masks
  assign desc       = desc_t'(main_attributes);
  assign sub_first  = first_sub(sub_attributes, 4'd0);
  assign sub_after  = first_sub(sub_attributes, {1'b0, st.skip_bit} + 4'd1);
  assign slot_first = first_slot(desc, 5'd0);
  assign slot_after = first_slot(desc, {1'b0, st.slot_counter} + 5'd1);
  assign vc_inc     = st.vertex_counter + 16'd1;
  assign fin_done   = (vc_inc >= st.count_held) || !(sub_first.found || slot_first.found);
  assign cur_word   = (st.slot_counter < LAST_SLOT_LIMIT) &&
                      (desc[st.slot_counter] == DESC_WORD);
  assign count_word = {st.count_high, data_byte};

  // Phase decode
  always_comb begin
    nxt       = st;
    end_req   = 1'b0;
    end_code  = REASON_DATA_END;
    hdr_req   = 1'b0;
    idx_req   = 1'b0;
    idx_done  = 1'b0;
    idx_value = {8'd0, data_byte};
    if (start_stream) begin
      nxt.stopped = 1'b0;
      nxt.phase   = PH_FLAGS;
    end
    if (!nxt.stopped) begin
      case (nxt.phase)
        PH_CNT_HI: begin
          nxt.count_high = data_byte;
          if (last_byte) begin
            end_req  = 1'b1;
            end_code = REASON_TRUNCATED;
          end else begin
            nxt.phase = PH_CNT_LO;
          end
        end
        PH_CNT_LO: begin
          nxt.count_held = count_word;
          if (count_word == 16'd0) begin
            end_req  = 1'b1;
            end_code = REASON_ZERO_COUNT;
          end else if (last_byte) begin
            end_req  = 1'b1;
            end_code = REASON_END_COUNT;
          end else if (main_attributes == 24'd0) begin
            end_req  = 1'b1;
            end_code = REASON_NO_MAIN;
          end else begin
            hdr_req = 1'b1;
            nxt = next_vertex(nxt, 16'd0, !(sub_first.found || slot_first.found),
                              sub_first, slot_first);
          end
        end
        PH_SKIP: begin
          if (sub_after.found) begin
            nxt.skip_bit = sub_after.idx;
          end else if (slot_first.found) begin
            nxt.phase        = PH_IDX;
            nxt.slot_counter = slot_first.idx;
          end else begin
            nxt      = next_vertex(nxt, vc_inc, fin_done, sub_first, slot_first);
            idx_done = fin_done;
          end
          if (last_byte) begin
            end_req  = 1'b1;
            end_code = idx_done ? REASON_DATA_END : REASON_TRUNCATED;
          end
        end
        PH_IDX, PH_IDX2: begin
          if ((nxt.phase == PH_IDX) && cur_word) begin
            // high byte of a 16-bit index
            nxt.value_high = data_byte;
            nxt.phase      = PH_IDX2;
            if (last_byte) begin
              end_req  = 1'b1;
              end_code = REASON_TRUNCATED;
            end
          end else begin
            if (nxt.phase == PH_IDX2) begin
              idx_value = {st.value_high, data_byte};
            end
            idx_req = 1'b1;
            if (slot_after.found) begin
              nxt.slot_counter = slot_after.idx;
              nxt.phase        = PH_IDX;
            end else begin
              nxt      = next_vertex(nxt, vc_inc, fin_done, sub_first, slot_first);
              idx_done = fin_done;
            end
          end
        end
        default: begin
          // flags byte
          nxt.flags_held = data_byte;
          nxt.count_held = 16'd0;
          if (data_byte == 8'd0) begin
            end_req  = 1'b1;
            end_code = REASON_ZERO_FLAGS;
          end else if (last_byte) begin
            end_req  = 1'b1;
            end_code = REASON_TRUNCATED;
          end else begin
            nxt.phase = PH_CNT_HI;
          end
        end
      endcase
    end

    // Result word
    emit = end_req || hdr_req || idx_req;
    res  = '0;
    res.primitive_type = nxt.flags_held[7:3];
    res.format_index   = nxt.flags_held[2:0];
    res.vertex_count   = nxt.count_held;
    if (end_req) begin
      nxt.stopped     = 1'b1;
      nxt.phase       = PH_FLAGS;
      res.kind        = KIND_END;
      res.stream_done = 1'b1;
      res.end_reason  = end_code;
    end else if (idx_req) begin
      res.kind              = KIND_INDEX;
      res.vertex_number     = st.vertex_counter;
      res.attribute_slot    = st.slot_counter;
      res.attribute_value   = idx_value;
      res.last_of_primitive = idx_done;
      if (last_byte) begin
        nxt.stopped     = 1'b1;
        nxt.phase       = PH_FLAGS;
        res.stream_done = 1'b1;
        res.end_reason  = idx_done ? REASON_DATA_END : REASON_TRUNCATED;
      end
    end else begin
      res.kind = KIND_HEADER;
    end
  end

endmodule

// File: rtl/display_list_primitive_parser.sv
// Display list primitive parser, top level: state, configuration and result
// registers around the per-byte step logic. Depends on dlpp_pkg, dlpp_if.sv
// and dlpp_step.
// A result word is registered and is valid in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the single output register stalls input
// whenever it holds a word that the receiver has not yet taken.
// Reset (synchronous, rst high) clears the parse state, both attribute
// registers and the output valid flag.
module display_list_primitive_parser (
  input  logic         clk,
  input  logic         rst,
  dlpp_cfg_if.sink     cfg,
  dlpp_byte_if.sink    bytes,
  dlpp_result_if.source results
);
  import dlpp_pkg::*;

  logic [23:0] main_attributes;
  logic [7:0]  sub_attributes;
  state_t      st;
  state_t      st_next;
  logic        emit;
  result_t     res_next;
  result_t     result;
  logic        out_valid;
  logic        in_acc;

  assign cfg.ready   = 1'b1;
  assign bytes.ready = !out_valid || results.ready;
  assign in_acc      = bytes.valid && bytes.ready;

  // Attribute registers
  always_ff @(posedge clk) begin
    if (rst) begin
      main_attributes <= 24'd0;
      sub_attributes  <= 8'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MAIN_ATTR: main_attributes <= cfg.data;
        CFG_SUB_ATTR:  sub_attributes  <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  dlpp_step u_step (
    .st              (st),
    .main_attributes (main_attributes),
    .sub_attributes  (sub_attributes),
    .data_byte       (bytes.data_byte),
    .last_byte       (bytes.last_byte),
    .start_stream    (bytes.start_stream),
    .nxt             (st_next),
    .emit            (emit),
    .res             (res_next)
  );

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      result <= res_next;
    end
  end

  assign results.valid             = out_valid;
  assign results.kind              = result.kind;
  assign results.primitive_type    = result.primitive_type;
  assign results.format_index      = result.format_index;
  assign results.vertex_count      = result.vertex_count;
  assign results.vertex_number     = result.vertex_number;
  assign results.attribute_slot    = result.attribute_slot;
  assign results.attribute_value   = result.attribute_value;
  assign results.last_of_primitive = result.last_of_primitive;
  assign results.stream_done       = result.stream_done;
  assign results.end_reason        = result.end_reason;

  // A word that ends the stream leaves the parser stopped
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    in_acc && emit && res_next.stream_done |=> st.stopped)
    else $error("parser not stopped after a stream-ending word");

  // Once stopped, bytes without a restart give nothing
  a_stopped_silent: assert property (@(posedge clk) disable iff (rst)
    in_acc && st.stopped && !bytes.start_stream |-> !emit)
    else $error("word produced while stopped");

  // An end word always carries the done flag
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.kind == KIND_END) |-> result.stream_done)
    else $error("end word without stream_done");

  // A header never ends the stream and names no index
  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.kind == KIND_HEADER) |->
      !result.stream_done && !result.last_of_primitive && (result.attribute_value == 16'd0))
    else $error("malformed header word");

endmodule

// File: dv/display_list_primitive_parser_tb.sv
// Testbench for the display list primitive parser: a directed table, then
// random display-list bursts checked word by word against a built-in predictor.
// Depends on dlpp_pkg, the channel interfaces and display_list_primitive_parser.
`timescale 1ns / 1ps

module display_list_primitive_parser_tb;
  import dlpp_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_BYTES = 1750;
  localparam int PHASE_BYTES  = 110;
  localparam int HOLD_CYCLES  = 300;

  logic clk;
  logic rst;

  dlpp_cfg_if    cfg_ch ();
  dlpp_byte_if   in_ch ();
  dlpp_result_if out_ch ();

  display_list_primitive_parser DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .bytes   (in_ch),
    .results (out_ch)
  );

  // Clock: 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser predictor: own copy of the registers and parse state
  // ---------------------------------------------------------------------------
  logic [23:0] desc_reg;
  logic [7:0]  skip_mask;
  phase_t      stage;
  logic [7:0]  hdr_flags;
  logic [7:0]  cnt_hi_byte;
  logic [15:0] prim_count;
  logic [15:0] vtx_idx;
  logic [3:0]  slot_idx;
  logic [2:0]  sub_idx;
  logic [7:0]  idx_hi_byte;
  bit          halted;

  result_t expected_q[$];

  // Append an expected word at the tail
  function automatic void queue_word(result_t w);
    expected_q.insert(expected_q.size(), w);
  endfunction

  // Lowest slot at or above 'from' that reads an index, -1 if none
  function automatic int find_slot(int from);
    for (int s = from; s < NUM_SLOTS; s++)
      if (desc_reg[2*s +: 2] >= DESC_BYTE) return s;
    return -1;
  endfunction

  // Lowest set skip bit at or above 'from', -1 if none
  function automatic int find_sub(int from);
    for (int b = from; b < 8; b++)
      if (skip_mask[b]) return b;
    return -1;
  endfunction

  function automatic bit begin_vertex();
    int b;
    int s;
    b = find_sub(0);
    if (b >= 0) begin
      stage   = PH_SKIP;
      sub_idx = 3'(b);
      return 1'b1;
    end
    s = find_slot(0);
    if (s >= 0) begin
      stage    = PH_IDX;
      slot_idx = 4'(s);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance to the next vertex; 1 when the primitive is complete
  function automatic bit end_vertex();
    vtx_idx = vtx_idx + 16'd1;
    if (vtx_idx >= prim_count || !begin_vertex()) begin
      stage = PH_FLAGS;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t mk_word(logic [1:0] kind, logic [15:0] vnum, logic [3:0] slot,
                                      logic [15:0] value, bit lastp, bit done,
                                      logic [2:0] reason);
    result_t w;
    w.kind              = kind;
    w.primitive_type    = hdr_flags[7:3];
    w.format_index      = hdr_flags[2:0];
    w.vertex_count      = prim_count;
    w.vertex_number     = vnum;
    w.attribute_slot    = slot;
    w.attribute_value   = value;
    w.last_of_primitive = lastp;
    w.stream_done       = done;
    w.end_reason        = reason;
    return w;
  endfunction

  function automatic result_t stop_with(logic [2:0] reason);
    halted = 1'b1;
    stage  = PH_FLAGS;
    return mk_word(KIND_END, 16'd0, 4'd0, 16'd0, 1'b0, 1'b1, reason);
  endfunction

  // One accepted byte; returns 1 with the word it causes, if any
  function automatic bit predict_byte(input logic [7:0] d, input bit lst, input bit st,
                                      output result_t r);
    int          s;
    int          b;
    bit          done;
    logic [15:0] value;
    logic [15:0] vnum;
    logic [3:0]  slot;
    r = '0;
    if (st) begin
      halted = 1'b0;
      stage  = PH_FLAGS;
    end
    if (halted) return 1'b0;
    case (stage)
      PH_CNT_HI: begin
        cnt_hi_byte = d;
        if (lst) begin
          r = stop_with(REASON_TRUNCATED);
          return 1'b1;
        end
        stage = PH_CNT_LO;
        return 1'b0;
      end
      PH_CNT_LO: begin
        prim_count = {cnt_hi_byte, d};
        if (prim_count == 16'd0) begin
          r = stop_with(REASON_ZERO_COUNT);
          return 1'b1;
        end
        if (lst) begin
          r = stop_with(REASON_END_COUNT);
          return 1'b1;
        end
        if (desc_reg == 24'd0) begin
          r = stop_with(REASON_NO_MAIN);
          return 1'b1;
        end
        vtx_idx = 16'd0;
        // a vertex that reads nothing completes the primitive at once
        if (!begin_vertex()) stage = PH_FLAGS;
        r = mk_word(KIND_HEADER, 16'd0, 4'd0, 16'd0, 1'b0, 1'b0, REASON_DATA_END);
        return 1'b1;
      end
      PH_SKIP: begin
        b    = find_sub(int'(sub_idx) + 1);
        done = 1'b0;
        if (b >= 0) begin
          sub_idx = 3'(b);
        end else begin
          s = find_slot(0);
          if (s >= 0) begin
            stage    = PH_IDX;
            slot_idx = 4'(s);
          end else begin
            done = end_vertex();
          end
        end
        if (lst) begin
          r = stop_with(done ? REASON_DATA_END : REASON_TRUNCATED);
          return 1'b1;
        end
        return 1'b0;
      end
      PH_IDX, PH_IDX2: begin
        if (stage == PH_IDX) begin
          // only a word descriptor takes a second byte
          if (slot_idx < NUM_SLOTS && desc_reg[2*slot_idx +: 2] == DESC_WORD) begin
            idx_hi_byte = d;
            stage       = PH_IDX2;
            if (lst) begin
              r = stop_with(REASON_TRUNCATED);
              return 1'b1;
            end
            return 1'b0;
          end
          value = {8'd0, d};
        end else begin
          value = {idx_hi_byte, d};
        end
        vnum = vtx_idx;
        slot = slot_idx;
        s    = find_slot(int'(slot) + 1);
        if (s >= 0) begin
          slot_idx = 4'(s);
          stage    = PH_IDX;
          done     = 1'b0;
        end else begin
          done = end_vertex();
        end
        if (lst) begin
          halted = 1'b1;
          stage  = PH_FLAGS;
          r = mk_word(KIND_INDEX, vnum, slot, value, done, 1'b1,
                      done ? REASON_DATA_END : REASON_TRUNCATED);
        end else begin
          r = mk_word(KIND_INDEX, vnum, slot, value, done, 1'b0, REASON_DATA_END);
        end
        return 1'b1;
      end
      default: begin
        hdr_flags  = d;
        prim_count = 16'd0;
        if (d == 8'd0) begin
          r = stop_with(REASON_ZERO_FLAGS);
          return 1'b1;
        end
        if (lst) begin
          r = stop_with(REASON_TRUNCATED);
          return 1'b1;
        end
        stage = PH_CNT_HI;
        return 1'b0;
      end
    endcase
    return 1'b0;
  endfunction

  // Bytes taken by one vertex under the current registers
  function automatic int vertex_bytes();
    int n;
    n = $countones(skip_mask);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (desc_reg[2*s +: 2] == DESC_WORD) n += 2;
      else if (desc_reg[2*s +: 2] == DESC_BYTE) n += 1;
    end
    return n;
  endfunction

  // Hand-typed word for the directed table
  function automatic result_t fixed_word(logic [1:0] kind, logic [7:0] flags,
                                         logic [15:0] count, bit done, logic [2:0] reason);
    result_t w;
    w                = '0;
    w.kind           = kind;
    w.primitive_type = flags[7:3];
    w.format_index   = flags[2:0];
    w.vertex_count   = count;
    w.stream_done    = done;
    w.end_reason     = reason;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  int errors = 0;
  int words_checked = 0;
  int live_bytes;
  int cycles = 0;
  bit calm;
  bit hold_req;
  bit hold_taken;
  int hold_left;

  function automatic string fmt_word(result_t w);
    return $sformatf({"kind=%0d type=%0d fmt=%0d count=%0d vtx=%0d slot=%0d ",
                      "val=%h last=%0d done=%0d reason=%0d"},
                     w.kind, w.primitive_type, w.format_index, w.vertex_count,
                     w.vertex_number, w.attribute_slot, w.attribute_value,
                     w.last_of_primitive, w.stream_done, w.end_reason);
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Result sink: check each accepted word, stall at random or during hold-off
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind              = out_ch.kind;
        got.primitive_type    = out_ch.primitive_type;
        got.format_index      = out_ch.format_index;
        got.vertex_count      = out_ch.vertex_count;
        got.vertex_number     = out_ch.vertex_number;
        got.attribute_slot    = out_ch.attribute_slot;
        got.attribute_value   = out_ch.attribute_value;
        got.last_of_primitive = out_ch.last_of_primitive;
        got.stream_done       = out_ch.stream_done;
        got.end_reason        = out_ch.end_reason;
        words_checked++;
        if (expected_q.size() == 0) begin
          flag_error($sformatf("unexpected word: %s", fmt_word(got)));
        end else begin
          want = expected_q.pop_front();
          if (got !== want)
            flag_error($sformatf("mismatch\n  expected %s\n  actual   %s",
                                 fmt_word(want), fmt_word(got)));
        end
      end
      out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 6);
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycles, expected_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one byte (valid held across back-to-back bytes) and predict on accept
  task automatic send_byte(logic [7:0] d, bit lst, bit st, bit has_fixed, result_t fixed);
    result_t r;
    bit      got;
    if (!calm && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 6);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= d;
    in_ch.last_byte    <= lst;
    in_ch.start_stream <= st;
    do @(posedge clk); while (!in_ch.ready);
    got = predict_byte(d, lst, st, r);
    if (has_fixed) queue_word(fixed);
    else if (got) queue_word(r);
    live_bytes++;
  endtask

  // Stop offering bytes and wait for every outstanding word, plus latency
  task automatic go_idle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; valid stays up for a following write
  task automatic put_reg(logic [1:0] idx, logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_MAIN_ATTR) desc_reg = val;
    else if (idx == CFG_SUB_ATTR) skip_mask = val[7:0];
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [23:0] reg_val;
    logic [7:0]  d;
    bit          lst;
    bit          st;
    bit          has_fixed;
    result_t     fixed;
  } plan_row_t;

  typedef struct {
    logic [7:0] d;
    bit         lst;
    bit         st;
  } burst_byte_t;

  plan_row_t   plan[$];
  burst_byte_t burst[$];

  // Append a row to the directed table
  function automatic void queue_row(plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  // Append a byte to the current burst
  function automatic void queue_burst_byte(logic [7:0] d, bit lst, bit st);
    burst_byte_t bb;
    bb.d   = d;
    bb.lst = lst;
    bb.st  = st;
    burst.insert(burst.size(), bb);
  endfunction

  task automatic add_cfg(logic [1:0] idx, logic [23:0] val);
    queue_row('{1'b1, idx, val, 8'd0, 1'b0, 1'b0, 1'b0, result_t'('0)});
  endtask

  task automatic add_byte(logic [7:0] d, bit lst, bit st);
    queue_row('{1'b0, 2'd0, 24'd0, d, lst, st, 1'b0, result_t'('0)});
  endtask

  task automatic add_fixed(logic [7:0] d, bit lst, bit st, result_t w);
    queue_row('{1'b0, 2'd0, 24'd0, d, lst, st, 1'b1, w});
  endtask

  // One random burst: mostly well-formed primitives, some truncated, some noise
  task automatic build_burst();
    int          nprim;
    int          bpv;
    int          body;
    int          cut;
    int          pick;
    logic [7:0]  flags;
    logic [15:0] count;
    burst.delete();
    bpv = vertex_bytes();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 12))
        queue_burst_byte(8'($urandom), $urandom_range(9) == 0, $urandom_range(7) == 0);
      return;
    end
    nprim = $urandom_range(1, 3);
    repeat (nprim) begin
      flags = ($urandom_range(24) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      pick  = $urandom_range(99);
      if (pick < 4) count = 16'd0;
      else if (pick < 8) count = 16'($urandom);
      else if (pick < 12) count = 16'hFFFF;
      else count = 16'($urandom_range(1, 4));
      queue_burst_byte(flags, 1'b0, 1'b0);
      queue_burst_byte(count[15:8], 1'b0, 1'b0);
      queue_burst_byte(count[7:0], 1'b0, 1'b0);
      body = int'(count) * bpv;
      if (body > 40) body = 40;
      repeat (body) queue_burst_byte(8'($urandom), 1'b0, 1'b0);
    end
    burst[0].st = 1'b1;
    // broken sequences: end the buffer early
    if ($urandom_range(99) < 25) begin
      cut = $urandom_range(0, burst.size() - 1);
      while (burst.size() > cut + 1) void'(burst.pop_back());
    end
    if ($urandom_range(99) < 85) burst[burst.size() - 1].lst = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    int          n_phases;
    int          phase_start;
    bit          in_cfg;
    logic [23:0] main_val;
    logic [7:0]  sub_val;

    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'd0;
    in_ch.last_byte    = 1'b0;
    in_ch.start_stream = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_MAIN_ATTR;
    cfg_ch.data        = 24'd0;
    calm               = 1'b0;
    hold_req           = 1'b0;
    live_bytes         = 0;
    n_phases           = 0;
    desc_reg           = 24'd0;
    skip_mask          = 8'd0;
    stage              = PH_FLAGS;
    hdr_flags          = 8'd0;
    cnt_hi_byte        = 8'd0;
    prim_count         = 16'd0;
    vtx_idx            = 16'd0;
    slot_idx           = 4'd0;
    sub_idx            = 3'd0;
    idx_hi_byte        = 8'd0;
    halted             = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // After reset: zero flags, then no main attributes, then bytes while stopped
    add_fixed(8'h00, 1'b0, 1'b1, fixed_word(KIND_END, 8'h00, 16'd0, 1'b1, REASON_ZERO_FLAGS));
    add_byte(8'hFF, 1'b0, 1'b1);
    add_byte(8'h00, 1'b0, 1'b0);
    add_fixed(8'h05, 1'b0, 1'b0, fixed_word(KIND_END, 8'hFF, 16'd5, 1'b1, REASON_NO_MAIN));
    add_byte(8'h12, 1'b0, 1'b0);
    // buffer ends on the flags byte
    add_fixed(8'h3C, 1'b1, 1'b1, fixed_word(KIND_END, 8'h3C, 16'd0, 1'b1, REASON_TRUNCATED));
    // all slots 16-bit indexes
    add_cfg(CFG_MAIN_ATTR, 24'hFFFFFF);
    add_cfg(CFG_SUB_ATTR, 24'h000000);
    add_byte(8'h08, 1'b0, 1'b1);
    add_byte(8'h00, 1'b0, 1'b0);
    add_fixed(8'h00, 1'b0, 1'b0, fixed_word(KIND_END, 8'h08, 16'd0, 1'b1, REASON_ZERO_COUNT));
    add_byte(8'h09, 1'b0, 1'b1);
    add_byte(8'h00, 1'b0, 1'b0);
    add_fixed(8'h01, 1'b1, 1'b0, fixed_word(KIND_END, 8'h09, 16'd1, 1'b1, REASON_END_COUNT));
    add_byte(8'hF8, 1'b0, 1'b1);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_fixed(8'hFF, 1'b0, 1'b0, fixed_word(KIND_HEADER, 8'hF8, 16'hFFFF, 1'b0, REASON_DATA_END));
    add_byte(8'hAB, 1'b0, 1'b0);
    add_byte(8'hCD, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    // byte index in slot 0 behind two skipped bytes
    add_cfg(CFG_MAIN_ATTR, 24'h000002);
    add_cfg(CFG_SUB_ATTR, 24'h000081);
    add_byte(8'h11, 1'b0, 1'b1);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h01, 1'b0, 1'b0);
    add_byte(8'h5A, 1'b0, 1'b0);
    add_byte(8'hA5, 1'b0, 1'b0);
    add_byte(8'h80, 1'b1, 1'b0);

    in_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!in_cfg) go_idle();
        put_reg(plan[i].reg_idx, plan[i].reg_val);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_ch.valid <= 1'b0;
        in_cfg = 1'b0;
        send_byte(plan[i].d, plan[i].lst, plan[i].st, plan[i].has_fixed, plan[i].fixed);
      end
    end

    // Random phases, each under its own register setting
    while (live_bytes < plan.size() + RANDOM_BYTES) begin
      go_idle();
      case (n_phases % 8)
        0: begin main_val = 24'hFFFFFF; sub_val = 8'h00; end
        1: begin main_val = 24'h000002; sub_val = 8'h00; end
        2: begin main_val = 24'hAAAAAA; sub_val = 8'hFF; end
        3: begin main_val = 24'h555555; sub_val = 8'($urandom_range(1)); end
        4: begin main_val = 24'h000000; sub_val = 8'($urandom); end
        5: begin main_val = 24'($urandom); sub_val = 8'($urandom); end
        6: begin main_val = 24'($urandom) | 24'h000002; sub_val = 8'h01; end
        default: begin main_val = 24'hC00000; sub_val = 8'h80; end
      endcase
      put_reg(CFG_MAIN_ATTR, main_val);
      put_reg(CFG_SUB_ATTR, {16'($urandom), sub_val});
      cfg_ch.valid <= 1'b0;
      calm = (n_phases == 5);
      // dense index words: the receiver holds off once so the block backs up
      if (n_phases == 1) hold_req <= 1'b1;
      phase_start = live_bytes;
      while (live_bytes - phase_start < PHASE_BYTES) begin
        build_burst();
        foreach (burst[j]) send_byte(burst[j].d, burst[j].lst, burst[j].st, 1'b0, '0);
      end
      n_phases++;
    end
    calm = 1'b0;

    go_idle();
    repeat (10) @(posedge clk);

    $display("Parser run: %0d bytes sent over %0d register settings, %0d result words checked",
             live_bytes, n_phases + 3, words_checked);
    $display("Covered all end reasons, byte and word indexes, skip masks and one long stall");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d errors", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dlpp_pkg.sv
rtl/dlpp_if.sv
rtl/dlpp_step.sv
rtl/display_list_primitive_parser.sv
dv/display_list_primitive_parser_tb.sv
